@@ hw/rtl/ftpc_pkg.sv @@
`default_nettype none

package ftpc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1024;
  localparam int unsigned MAX_NAME_BYTES   = 256;
  localparam int unsigned MAX_SIZE_BYTES   = 6;

  localparam int unsigned NAME_DEPTH = 256;
  localparam int unsigned NAME_AW    = 8;
  localparam int unsigned SIZE_W     = 48;
  localparam int unsigned POS_W      = 16;

  // packet type bytes
  localparam logic [7:0] TYPE_DATA  = 8'h01;
  localparam logic [7:0] TYPE_START = 8'h02;
  localparam logic [7:0] TYPE_END   = 8'h03;

  // control field tags
  localparam logic [7:0] TAG_SIZE = 8'h00;
  localparam logic [7:0] TAG_NAME = 8'h01;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_START = 2'd1,
    KIND_END   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_MISMATCH  = 3'd4
  } status_e;

  // control packet parse steps (low three bits of the field stage)
  localparam logic [2:0] STEP_TAG0 = 3'd0;
  localparam logic [2:0] STEP_LEN0 = 3'd1;
  localparam logic [2:0] STEP_VAL0 = 3'd2;
  localparam logic [2:0] STEP_TAG1 = 3'd3;
  localparam logic [2:0] STEP_LEN1 = 3'd4;
  localparam logic [2:0] STEP_VAL1 = 3'd5;
  localparam logic [2:0] STEP_DONE = 3'd6;

  // data packet parse stages
  localparam logic [3:0] DSTG_LEN_HI  = 4'd0;
  localparam logic [3:0] DSTG_LEN_LO  = 4'd1;
  localparam logic [3:0] DSTG_PAYLOAD = 4'd2;

endpackage

`default_nettype wire

@@ hw/rtl/ftpc_ram.sv @@
`default_nettype none

module ftpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/file_transfer_packet_checker_top.sv @@
`default_nettype none

// Receive-side file transfer packet checker. Takes one packet byte per cycle
// (tlast on the final byte) and returns exactly one output item per byte in
// the cycle after acceptance; with m_axis_tready high, one byte per clock is
// sustained. Each output item carries a forwarded payload or name byte when
// out_valid is set, and on the final byte of a packet (tlast) the verdict:
// packet kind, status, decoded file size and transfer_done. A start packet
// must open a transfer; data packets follow and an end packet that repeats
// the start's size and name closes it. Any error sends the checker back to
// waiting for a start packet. The start's name is kept in a 256 x 8 RAM with
// registered read; the entry for the next byte is fetched ahead, so the RAM
// port does not slow the stream. No clearing pass after reset.
module file_transfer_packet_checker_top
  import ftpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // in_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_valid[0], out_byte[8:1], packet_kind[10:9], status[13:11],
  // decoded_size[61:14], transfer_done[62], zero[63]
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // out_kind
  output logic             m_axis_tlast   // packet_done
);

  // parser state
  logic              in_pkt_q, in_pkt_d;
  logic              phase_q, phase_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  kind_e             kind_q, kind_d;
  logic [3:0]        stage_q, stage_d;
  logic [7:0]        remain_q, remain_d;
  logic [POS_W-1:0]  decl_q, decl_d;
  logic [SIZE_W-1:0] acc_q, acc_d;
  logic [SIZE_W-1:0] stored_size_q, stored_size_d;
  logic [7:0]        name_len_q, name_len_d;
  logic [2:0]        err_q, err_d;

  // output register
  logic              m_valid_q;
  logic              o_valid_q, o_valid_d;
  logic              o_kind_q, o_kind_d;
  logic [7:0]        o_byte_q, o_byte_d;
  logic              o_done_q, o_done_d;
  logic [1:0]        o_pkind_q, o_pkind_d;
  logic [2:0]        o_status_q, o_status_d;
  logic [SIZE_W-1:0] o_size_q, o_size_d;
  logic              o_xfer_q, o_xfer_d;

  logic              s_fire;
  logic [7:0]        b;

  logic              ram_we;
  logic [NAME_AW-1:0] ram_waddr;
  logic [NAME_AW-1:0] ram_raddr;
  logic [NAME_AW-1:0] name_idx;
  logic [7:0]        ram_rdata;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  // name index of the byte about to be parsed
  assign name_idx  = decl_q[NAME_AW-1:0] - remain_q;
  assign ram_waddr = name_idx;
  // fetch ahead: address of the item after this one while accepting
  assign ram_raddr = s_fire ? (decl_d[NAME_AW-1:0] - remain_d) : name_idx;

  ftpc_ram #(
    .WIDTH(8),
    .DEPTH(NAME_DEPTH)
  ) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(b),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  function automatic logic halted(input logic [2:0] e);
    return (e == ST_BAD_TYPE) || (e == ST_MALFORMED) || (e == ST_LEN_ERR);
  endfunction

  always_comb begin
    logic [2:0] step;
    logic       name_first;
    logic       is_name;
    logic       ok;

    in_pkt_d      = in_pkt_q;
    phase_d       = phase_q;
    pos_d         = pos_q;
    kind_d        = kind_q;
    stage_d       = stage_q;
    remain_d      = remain_q;
    decl_d        = decl_q;
    acc_d         = acc_q;
    stored_size_d = stored_size_q;
    name_len_d    = name_len_q;
    err_d         = err_q;

    o_valid_d  = 1'b0;
    o_kind_d   = 1'b0;
    o_byte_d   = 8'd0;
    o_done_d   = 1'b0;
    o_pkind_d  = 2'd0;
    o_status_d = ST_OK;
    o_size_d   = '0;
    o_xfer_d   = 1'b0;

    ram_we     = 1'b0;
    step       = stage_q[2:0];
    name_first = stage_q[3];
    is_name    = 1'b0;
    ok         = 1'b1;

    if (s_fire) begin
      if (!in_pkt_q) begin
        // type byte
        in_pkt_d = 1'b1;
        stage_d  = '0;
        remain_d = '0;
        decl_d   = '0;
        acc_d    = '0;
        err_d    = ST_OK;
        pos_d    = POS_W'(1);
        if (!phase_q) begin
          kind_d = (b == TYPE_START) ? KIND_START : KIND_BAD;
        end else if (b == TYPE_DATA) begin
          kind_d = KIND_DATA;
          pos_d  = '0;
        end else begin
          kind_d = (b == TYPE_END) ? KIND_END : KIND_BAD;
        end
        if (kind_d == KIND_BAD) begin
          err_d = ST_BAD_TYPE;
        end
      end else if (!halted(err_q)) begin
        if (kind_q == KIND_DATA) begin
          if (stage_q == DSTG_LEN_HI) begin
            decl_d  = {b, 8'd0};
            stage_d = DSTG_LEN_LO;
          end else if (stage_q == DSTG_LEN_LO) begin
            decl_d  = {decl_q[15:8], b};
            stage_d = DSTG_PAYLOAD;
            pos_d   = '0;
          end else if (pos_q >= decl_q || pos_q >= POS_W'(MAX_PACKET_BYTES - 3)) begin
            err_d = ST_LEN_ERR;
          end else begin
            o_valid_d = 1'b1;
            o_byte_d  = b;
            if (pos_q != '1) begin
              pos_d = pos_q + POS_W'(1);
            end
          end
        end else begin
          if (pos_q >= POS_W'(MAX_PACKET_BYTES)) begin
            err_d = ST_MALFORMED;
            ok    = 1'b0;
          end else begin
            case (step)
              STEP_TAG0: begin
                if (b > TAG_NAME) begin
                  err_d = ST_MALFORMED;
                  ok    = 1'b0;
                end else begin
                  name_first = b[0];
                  step       = STEP_LEN0;
                end
              end
              STEP_TAG1: begin
                if (b != (name_first ? TAG_SIZE : TAG_NAME)) begin
                  err_d = ST_MALFORMED;
                  ok    = 1'b0;
                end else begin
                  step = STEP_LEN1;
                end
              end
              STEP_LEN0, STEP_LEN1: begin
                is_name = (step == STEP_LEN0) ? name_first : !name_first;
                if (is_name && {1'b0, b} > 9'(MAX_NAME_BYTES)) begin
                  err_d = ST_MALFORMED;
                  ok    = 1'b0;
                end else if (!is_name && {24'd0, b} > 32'(MAX_SIZE_BYTES)) begin
                  err_d = ST_MALFORMED;
                  ok    = 1'b0;
                end else begin
                  if (is_name) begin
                    if (kind_q == KIND_START) begin
                      name_len_d = b;
                    end else if (b != name_len_q && err_q == ST_OK) begin
                      err_d = ST_MISMATCH;
                    end
                  end
                  decl_d   = {8'd0, b};
                  remain_d = b;
                  step     = (b != 8'd0) ? step + 3'd1 : step + 3'd2;
                end
              end
              STEP_VAL0, STEP_VAL1: begin
                is_name = (step == STEP_VAL0) ? name_first : !name_first;
                if (is_name) begin
                  if (kind_q == KIND_START) begin
                    ram_we    = 1'b1;
                    o_valid_d = 1'b1;
                    o_kind_d  = 1'b1;
                    o_byte_d  = b;
                  end else if (name_idx < name_len_q && ram_rdata != b
                               && err_q == ST_OK) begin
                    err_d = ST_MISMATCH;
                  end
                end else begin
                  acc_d = {acc_q[SIZE_W-9:0], b};
                end
                remain_d = remain_q - 8'd1;
                if (remain_d == 8'd0) begin
                  step = step + 3'd1;
                end
              end
              default: begin
                err_d = ST_MALFORMED;
                ok    = 1'b0;
              end
            endcase
          end
          if (ok) begin
            stage_d = {name_first, step};
          end
          if (pos_q != '1) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end

      if (s_axis_tlast) begin
        if (kind_d == KIND_DATA) begin
          if (err_d == ST_OK && (stage_d != DSTG_PAYLOAD || pos_d != decl_d)) begin
            err_d = ST_LEN_ERR;
          end
        end else if (kind_d != KIND_BAD) begin
          if (!halted(err_d) && stage_d[2:0] != STEP_DONE) begin
            err_d = ST_MALFORMED;
          end
          if (kind_d == KIND_END && err_d == ST_OK && acc_d != stored_size_q) begin
            err_d = ST_MISMATCH;
          end
          o_size_d = acc_d;
        end
        o_done_d   = 1'b1;
        o_pkind_d  = kind_d;
        o_status_d = err_d;
        if (err_d != ST_OK) begin
          phase_d = 1'b0;
        end else if (kind_d == KIND_START) begin
          phase_d       = 1'b1;
          stored_size_d = acc_d;
        end else if (kind_d == KIND_END) begin
          phase_d  = 1'b0;
          o_xfer_d = 1'b1;
        end
        in_pkt_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q      <= 1'b0;
      phase_q       <= 1'b0;
      pos_q         <= '0;
      kind_q        <= KIND_DATA;
      stage_q       <= '0;
      remain_q      <= '0;
      decl_q        <= '0;
      acc_q         <= '0;
      stored_size_q <= '0;
      name_len_q    <= '0;
      err_q         <= ST_OK;
      m_valid_q     <= 1'b0;
    end else begin
      in_pkt_q      <= in_pkt_d;
      phase_q       <= phase_d;
      pos_q         <= pos_d;
      kind_q        <= kind_d;
      stage_q       <= stage_d;
      remain_q      <= remain_d;
      decl_q        <= decl_d;
      acc_q         <= acc_d;
      stored_size_q <= stored_size_d;
      name_len_q    <= name_len_d;
      err_q         <= err_d;
      if (s_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      o_valid_q  <= o_valid_d;
      o_kind_q   <= o_kind_d;
      o_byte_q   <= o_byte_d;
      o_done_q   <= o_done_d;
      o_pkind_q  <= o_pkind_d;
      o_status_q <= o_status_d;
      o_size_q   <= o_size_d;
      o_xfer_q   <= o_xfer_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, o_xfer_q, o_size_q, o_status_q, o_pkind_q, o_byte_q, o_valid_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_done_q;

`ifndef SYNTHESIS
  a_status_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && o_status_q != ST_OK |-> o_done_q)
    else $error("verdict status on a byte that is not the last");

  a_xfer_is_clean_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && o_xfer_q |-> o_status_q == ST_OK && o_pkind_q == KIND_END)
    else $error("transfer_done without a clean end packet");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !o_valid_q |-> o_byte_q == 8'd0 && !o_kind_q)
    else $error("non-forwarded item carries a byte");

  a_pkt_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_pkt_q) |-> $past(s_fire && s_axis_tlast))
    else $error("packet closed without a last byte");

  a_session_opens_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q) |-> $past(kind_d == KIND_START && err_d == ST_OK && s_axis_tlast))
    else $error("session opened without a clean start packet");
`endif

endmodule

`default_nettype wire

@@ test/tb_file_transfer_packet_checker_top.sv @@
module tb_file_transfer_packet_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ftpc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
  } wire_byte_t;

  // what the checker should return for one accepted byte
  typedef struct packed {
    logic        fwd;
    logic        name_byte;
    logic [7:0]  data;
    logic        done;
    kind_e       kind;
    status_e     status;
    logic [47:0] fsize;
    logic        xfer_done;
  } checker_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // in_byte
  logic        s_axis_tlast = 1'b0;    // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_valid[0], out_byte[8:1], packet_kind[10:9], status[13:11],
  // decoded_size[61:14], transfer_done[62], zero[63]
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;           // out_kind
  logic        m_axis_tlast;           // packet_done

  file_transfer_packet_checker_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  wire_byte_t   pending_bytes[$];
  checker_out_t checker_out_q[$];
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;
  int unsigned  fail_count = 0;
  int unsigned  gen_count = 0;
  bit           in_taken = 1'b0;
  wire_byte_t   next_byte;
  checker_out_t pred_in;
  checker_out_t pred_out;

  // predictor state
  logic        in_transfer = 1'b0;
  logic        mid_packet = 1'b0;
  logic [15:0] pos = '0;
  kind_e       cur_kind = KIND_DATA;
  logic [3:0]  stage = '0;
  logic [7:0]  remain = '0;
  logic [15:0] decl_len = '0;
  logic [47:0] size_acc = '0;
  logic [47:0] start_size = '0;
  logic [7:0]  start_name [NAME_DEPTH];
  logic [7:0]  start_name_len = '0;
  status_e     perr = ST_OK;

  // stimulus builder state
  logic [7:0]  pkt[$];
  logic [7:0]  f_size[$];
  logic [7:0]  f_name[$];
  logic [7:0]  sess_size[$];
  logic [7:0]  sess_name[$];

  function automatic logic is_halted();
    return perr == ST_BAD_TYPE || perr == ST_MALFORMED || perr == ST_LEN_ERR;
  endfunction

  task automatic ctrl_byte(input logic [7:0] b, inout checker_out_t r);
    logic [2:0] step;
    logic       name_first;
    logic       is_name;
    logic       bad;
    logic [7:0] idx;
    step = stage[2:0];
    name_first = stage[3];
    bad = 1'b0;
    if (pos >= MAX_PACKET_BYTES) begin
      bad = 1'b1;
    end else begin
      case (step)
        STEP_TAG0: begin
          if (b > TAG_NAME) bad = 1'b1;
          name_first = (b == TAG_NAME);
          step = STEP_LEN0;
        end
        STEP_TAG1: begin
          if (b != (name_first ? TAG_SIZE : TAG_NAME)) bad = 1'b1;
          step = STEP_LEN1;
        end
        STEP_LEN0, STEP_LEN1: begin
          is_name = (step == STEP_LEN0) ? name_first : !name_first;
          if (is_name) begin
            if (b > MAX_NAME_BYTES) bad = 1'b1;
            else if (cur_kind == KIND_START) start_name_len = b;
            else if (b != start_name_len && perr == ST_OK) perr = ST_MISMATCH;
          end else if (b > MAX_SIZE_BYTES) begin
            bad = 1'b1;
          end
          decl_len = {8'h00, b};
          remain = b;
          step = (b != 8'h00) ? step + 3'd1 : step + 3'd2;
        end
        STEP_VAL0, STEP_VAL1: begin
          idx = decl_len[7:0] - remain;
          is_name = (step == STEP_VAL0) ? name_first : !name_first;
          if (is_name) begin
            if (cur_kind == KIND_START) begin
              start_name[idx] = b;
              r.fwd = 1'b1;
              r.name_byte = 1'b1;
              r.data = b;
            end else if (idx < start_name_len && start_name[idx] != b && perr == ST_OK) begin
              perr = ST_MISMATCH;
            end
          end else begin
            size_acc = {size_acc[39:0], b};
          end
          remain = remain - 8'd1;
          if (remain == 8'd0) step = step + 3'd1;
        end
        default: bad = 1'b1;
      endcase
    end
    if (bad) perr = ST_MALFORMED;
    else stage = {name_first, step};
  endtask

  task automatic data_byte(input logic [7:0] b, inout checker_out_t r);
    case (stage)
      DSTG_LEN_HI: begin
        decl_len = {b, 8'h00};
        stage = DSTG_LEN_LO;
      end
      DSTG_LEN_LO: begin
        decl_len[7:0] = b;
        stage = DSTG_PAYLOAD;
        pos = '0;
      end
      default: begin
        if (pos >= decl_len || pos >= MAX_PACKET_BYTES - 3) begin
          perr = ST_LEN_ERR;
        end else begin
          r.fwd = 1'b1;
          r.data = b;
          if (pos != 16'hFFFF) pos = pos + 16'd1;
        end
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop, output checker_out_t r);
    r = '0;
    if (!mid_packet) begin
      mid_packet = 1'b1;
      stage = '0;
      remain = '0;
      decl_len = '0;
      size_acc = '0;
      perr = ST_OK;
      pos = 16'd1;
      if (!in_transfer) begin
        cur_kind = (b == TYPE_START) ? KIND_START : KIND_BAD;
      end else if (b == TYPE_DATA) begin
        cur_kind = KIND_DATA;
        pos = '0;
      end else begin
        cur_kind = (b == TYPE_END) ? KIND_END : KIND_BAD;
      end
      if (cur_kind == KIND_BAD) perr = ST_BAD_TYPE;
    end else if (!is_halted()) begin
      if (cur_kind == KIND_DATA) begin
        data_byte(b, r);
      end else begin
        ctrl_byte(b, r);
        if (pos != 16'hFFFF) pos = pos + 16'd1;
      end
    end
    if (eop) begin
      if (cur_kind == KIND_DATA) begin
        if (perr == ST_OK && (stage != DSTG_PAYLOAD || pos != decl_len)) perr = ST_LEN_ERR;
      end else if (cur_kind != KIND_BAD) begin
        // malformed wins over an end mismatch seen earlier
        if (!is_halted() && stage[2:0] != STEP_DONE) perr = ST_MALFORMED;
        if (cur_kind == KIND_END && perr == ST_OK && size_acc != start_size)
          perr = ST_MISMATCH;
        r.fsize = size_acc;
      end
      r.done = 1'b1;
      r.kind = cur_kind;
      r.status = perr;
      if (perr != ST_OK) begin
        in_transfer = 1'b0;
      end else if (cur_kind == KIND_START) begin
        in_transfer = 1'b1;
        start_size = size_acc;
      end else if (cur_kind == KIND_END) begin
        in_transfer = 1'b0;
        r.xfer_done = 1'b1;
      end
      mid_packet = 1'b0;
    end
  endtask

  function automatic void cmp_field(input string fname, input logic [47:0] want,
                                    input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (rst_ni && pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_byte = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= next_byte.data;
        s_axis_tlast <= next_byte.eop;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  // monitor: both handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    in_taken = s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      if (checker_out_q.size() == 0) begin
        $display("%0t: unexpected output item, expected none actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        pred_out = checker_out_q.pop_front();
        cmp_field("out_valid", pred_out.fwd, m_axis_tdata[0]);
        cmp_field("out_byte", pred_out.data, m_axis_tdata[8:1]);
        cmp_field("packet_kind", pred_out.kind, m_axis_tdata[10:9]);
        cmp_field("status", pred_out.status, m_axis_tdata[13:11]);
        cmp_field("decoded_size", pred_out.fsize, m_axis_tdata[61:14]);
        cmp_field("transfer_done", pred_out.xfer_done, m_axis_tdata[62]);
        cmp_field("pad bit", 48'd0, m_axis_tdata[63]);
        cmp_field("out_kind", pred_out.name_byte, m_axis_tuser);
        cmp_field("packet_done", pred_out.done, m_axis_tlast);
      end
    end
    if (in_taken) begin
      parse_byte(s_axis_tdata, s_axis_tlast, pred_in);
      checker_out_q.push_back(pred_in);
    end
  end

  task automatic emit_packet();
    wire_byte_t w;
    int i;
    for (i = 0; i < pkt.size(); i++) begin
      w.data = pkt[i];
      w.eop = (i == pkt.size() - 1);
      pending_bytes.push_back(w);
    end
    gen_count += pkt.size();
  endtask

  task automatic put_fields(input logic name_first);
    int k;
    for (k = 0; k < 2; k++) begin
      if ((k == 0) == name_first) begin
        pkt.push_back(TAG_NAME);
        pkt.push_back(8'(f_name.size()));
        foreach (f_name[j]) pkt.push_back(f_name[j]);
      end else begin
        pkt.push_back(TAG_SIZE);
        pkt.push_back(8'(f_size.size()));
        foreach (f_size[j]) pkt.push_back(f_size[j]);
      end
    end
  endtask

  task automatic build_start();
    int slen;
    int nlen;
    int fill;
    int i;
    slen = $urandom_range(MAX_SIZE_BYTES);
    nlen = ($urandom_range(19) == 0) ? $urandom_range(200, 255) : $urandom_range(12);
    fill = $urandom_range(3);
    f_size.delete();
    f_name.delete();
    for (i = 0; i < slen; i++) begin
      case (fill)
        0: f_size.push_back(8'hFF);
        1: f_size.push_back(8'h00);
        default: f_size.push_back(8'($urandom_range(255)));
      endcase
    end
    for (i = 0; i < nlen; i++) f_name.push_back(8'($urandom_range(255)));
    sess_size = f_size;
    sess_name = f_name;
    pkt.delete();
    pkt.push_back(TYPE_START);
    put_fields(1'($urandom_range(1)));
  endtask

  task automatic build_end();
    int i;
    f_size = sess_size;
    f_name = sess_name;
    // occasionally disagree with the start packet, or re-encode the same size
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: begin
          if (f_name.size() != 0) begin
            i = $urandom_range(f_name.size() - 1);
            f_name[i] = f_name[i] ^ 8'($urandom_range(1, 255));
          end
        end
        1: if (f_name.size() < 255) f_name.push_back(8'($urandom_range(255)));
        2: if (f_name.size() != 0) void'(f_name.pop_back());
        3: begin
          if (f_size.size() != 0) begin
            i = $urandom_range(f_size.size() - 1);
            f_size[i] = f_size[i] ^ 8'($urandom_range(1, 255));
          end else begin
            f_size.push_back(8'($urandom_range(1, 255)));
          end
        end
        default: if (f_size.size() < MAX_SIZE_BYTES) f_size.push_front(8'h00);
      endcase
    end
    pkt.delete();
    pkt.push_back(TYPE_END);
    put_fields(1'($urandom_range(1)));
  endtask

  task automatic build_data(input int len);
    int i;
    pkt.delete();
    pkt.push_back(TYPE_DATA);
    pkt.push_back(8'(len >> 8));
    pkt.push_back(8'(len));
    for (i = 0; i < len; i++) pkt.push_back(8'($urandom_range(255)));
  endtask

  task automatic maybe_corrupt();
    int i;
    int n;
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0: begin
          if (pkt.size() > 1) begin
            n = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > n) void'(pkt.pop_back());
          end
        end
        1: begin
          n = $urandom_range(1, 3);
          repeat (n) pkt.push_back(8'($urandom_range(255)));
        end
        2: begin
          i = $urandom_range(pkt.size() - 1);
          case ($urandom_range(5))
            0: pkt[i] = TAG_SIZE;
            1: pkt[i] = TAG_NAME;
            2: pkt[i] = TYPE_START;
            3: pkt[i] = 8'(MAX_SIZE_BYTES + 1);
            4: pkt[i] = 8'hFF;
            default: pkt[i] = 8'($urandom_range(255));
          endcase
        end
        default: pkt[0] = 8'($urandom_range(255));
      endcase
    end
    emit_packet();
  endtask

  task automatic gen_transfer(input int long_len);
    int n_data;
    int len;
    n_data = $urandom_range(4);
    build_start();
    maybe_corrupt();
    if (long_len != 0) begin
      build_data(long_len);
      emit_packet();
    end
    repeat (n_data) begin
      len = ($urandom_range(14) == 0) ? $urandom_range(64, 300) : $urandom_range(24);
      build_data(len);
      maybe_corrupt();
    end
    build_end();
    maybe_corrupt();
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 5);
    pkt.delete();
    repeat (n) pkt.push_back(8'($urandom_range(255)));
    emit_packet();
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid || checker_out_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int budget, input int long_len);
    int unsigned base;
    src_idle_pct = idle;
    snk_stall_pct = stall;
    base = gen_count;
    if (long_len != 0) gen_transfer(long_len);
    while (gen_count - base < budget) begin
      if ($urandom_range(19) == 0) gen_noise();
      else gen_transfer(0);
    end
    // sender holds off until every result is back
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // type byte at its top value while waiting for start
    pkt = '{8'hFF};
    emit_packet();
    // start: name first, size at the top byte value
    pkt = '{TYPE_START, TAG_NAME, 8'd2, 8'h41, 8'h42, TAG_SIZE, 8'd1, 8'hFF};
    emit_packet();
    pkt = '{TYPE_DATA, 8'h00, 8'd1, 8'h00};
    emit_packet();
    // empty payload
    pkt = '{TYPE_DATA, 8'h00, 8'h00};
    emit_packet();
    // end repeats the start with the fields swapped
    pkt = '{TYPE_END, TAG_SIZE, 8'd1, 8'hFF, TAG_NAME, 8'd2, 8'h41, 8'h42};
    emit_packet();
    wait_drained();

    // payload past the packet limit in the phase without idling
    run_phase(0, 0, 500, MAX_PACKET_BYTES + 6);
    run_phase(85, 0, 300, 0);
    run_phase(0, 85, 300, 0);
    run_phase(28, 28, 300, 0);

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("file_transfer_packet_checker_top regression: pass");
    end else begin
      $display("file_transfer_packet_checker_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("file_transfer_packet_checker_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ftpc_pkg.sv
hw/rtl/ftpc_ram.sv
hw/rtl/file_transfer_packet_checker_top.sv
test/tb_file_transfer_packet_checker_top.sv
